/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// shared assertion macros for the alarm schedule table checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ALM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("alarm schedule table check failed");

// implication into the next cycle
`define ALM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("alarm schedule table sequence check failed");

`endif

/* rtl/core/alm_sched_pkg.sv */
// ----------------------------------------------------------------------------
// alm_sched_pkg
// types and codes of the alarm schedule table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alm_sched_pkg;

  // request types
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_SETEN  = 2'd3;

  // entry kinds
  localparam logic [1:0] KIND_PERIODIC = 2'd0;
  localparam logic [1:0] KIND_DAILY    = 2'd1;
  localparam logic [1:0] KIND_ONESHOT  = 2'd2;

  // result status codes
  localparam logic [1:0] STS_DONE      = 2'd0;
  localparam logic [1:0] STS_FULL      = 2'd1;
  localparam logic [1:0] STS_NOT_FOUND = 2'd2;

  // configuration
  localparam logic        CFG_IDX_MIN_YEAR = 1'b0;
  localparam logic [13:0] MIN_YEAR_RST     = 14'd2024;

  // packed date yyyymmdd
  localparam logic [31:0] DATE_YEAR_MUL  = 32'd10000;
  localparam logic [31:0] DATE_MONTH_MUL = 32'd100;

  // id map: 256 ids as rows of 16 bits
  localparam int ID_ROWS  = 16;
  localparam int ID_ROW_W = 16;

  typedef struct packed {
    logic [7:0]  id;
    logic [1:0]  kind;
    logic        en;
    logic        done;
    logic [31:0] interval;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [31:0] prev_fire;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_IDSCAN,
    ST_WRITE,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/alarm_schedule_table.sv */
// ----------------------------------------------------------------------------
// alarm_schedule_table
// table of periodic, daily and one-shot alarm entries with add, remove,
// set-enable and tick requests
// ----------------------------------------------------------------------------
// One request item is handled at a time. The table lives in a memory with one
// registered read port that is walked one slot per cycle; a single 32-bit
// adder and comparator checks whether the slot is due. A tick scans the slots
// until an entry fires and then writes that entry back; remove scans without
// a write, and set-enable scans and then writes the entry. An add scans for
// the first free slot and then the id map one row of 16 ids per cycle. The
// result waits in an output register, so a new item can be taken while it is
// pending. Valid bits and the id map are cleared by reset directly, so no
// clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module alarm_schedule_table
  import alm_sched_pkg::*;
#(
  parameter int ENTRY_COUNT = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] now_sec_i,
  input  wire logic [13:0] cal_year_i,
  input  wire logic [3:0]  cal_month_i,
  input  wire logic [4:0]  cal_day_i,
  input  wire logic [4:0]  hour_i,
  input  wire logic [5:0]  minute_i,
  input  wire logic [1:0]  entry_kind_i,
  input  wire logic [31:0] period_sec_i,
  input  wire logic        enable_flag_i,
  input  wire logic [7:0]  target_id_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [7:0]       result_id_o,
  output logic             fired_o,
  output logic [3:0]       fired_slot_o,
  output logic [4:0]       entry_count_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CW = $clog2(ENTRY_COUNT + 1);
  localparam logic [SW-1:0] LAST_IDX = SW'(ENTRY_COUNT - 1);
  localparam int RW = $clog2(ID_ROWS);
  localparam int BW = $clog2(ID_ROW_W);
  localparam logic [RW-1:0] LAST_ROW = RW'(ID_ROWS - 1);

  function automatic logic [BW-1:0] lowest_set(input logic [ID_ROW_W-1:0] v);
    logic [BW-1:0] pos;
    pos = '0;
    for (int b = ID_ROW_W - 1; b >= 0; b--) begin
      if (v[b]) begin
        pos = BW'(b);
      end
    end
    return pos;
  endfunction

  // configuration
  logic [13:0] cfg_year_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_MIN_YEAR);
  assign prdata = (paddr[2] == CFG_IDX_MIN_YEAR) ? {18'd0, cfg_year_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_year_q <= MIN_YEAR_RST;
    end else if (cfg_wr) begin
      cfg_year_q <= pwdata[13:0];
    end
  end

  // control state
  state_e              state_q, state_d;
  logic [SW-1:0]       idx_q, idx_d;
  logic [SW-1:0]       slot_q, slot_d;
  logic [RW-1:0]       row_q, row_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [ENTRY_COUNT-1:0] vld_q, vld_d;
  logic [ID_ROW_W-1:0] idmap_q [ID_ROWS];
  logic [ID_ROW_W-1:0] idmap_d [ID_ROWS];
  logic                ovld_q, ovld_d;

  // request and result payload
  logic [1:0]  req_q;
  logic [31:0] now_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [1:0]  kind_q;
  logic [31:0] ival_q;
  logic        en_q;
  logic [7:0]  tid_q;
  logic [31:0] today_q;
  logic        year_ok_q;
  entry_t      wr_q, wr_d;
  logic [1:0]  sts_q, sts_d;
  logic [7:0]  rid_q, rid_d;
  logic        fired_q, fired_d;
  logic [SW-1:0] fslot_q, fslot_d;
  logic [1:0]  o_sts_q;
  logic [7:0]  o_rid_q;
  logic        o_fired_q;
  logic [3:0]  o_fslot_q;
  logic [4:0]  o_cnt_q;
  logic        in_acc;
  logic        out_load;

  // table memory
  entry_t mem_q [ENTRY_COUNT];
  entry_t rd_q;
  logic   mem_we;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_q] <= wr_q;
    end
    rd_q <= mem_q[idx_d];
  end

  // shared add and compare unit
  entry_t      ent;
  logic        is_per;
  logic [31:0] add_a, add_b, sum, cmp_a, cmp_b;
  logic        ge, due;
  entry_t      upd;
  logic [ID_ROW_W-1:0] row_free;
  logic [BW-1:0] free_bit;

  assign ent    = vld_q[idx_q] ? rd_q : '0;
  assign is_per = (ent.kind == KIND_PERIODIC);
  assign add_a  = is_per ? now_q : ent.prev_fire;
  assign add_b  = is_per ? ~ent.prev_fire : ent.interval;
  assign sum    = add_a + add_b + {31'd0, is_per};
  assign cmp_a  = is_per ? sum : now_q;
  assign cmp_b  = is_per ? ent.interval : sum;
  assign ge     = (cmp_a >= cmp_b);

  always_comb begin
    due = 1'b0;
    upd = ent;
    if (ent.en) begin
      case (ent.kind)
        KIND_PERIODIC: begin
          due           = (ent.interval != '0) && ge;
          upd.prev_fire = now_q;
        end
        KIND_DAILY: begin
          due = year_ok_q && (hour_q == ent.hour) && (minute_q == ent.minute)
                && (ent.prev_fire != today_q);
          upd.prev_fire = today_q;
        end
        KIND_ONESHOT: begin
          due      = !ent.done && (ent.interval != '0) && ge;
          upd.done = 1'b1;
          upd.en   = 1'b0;
        end
        default: begin
          due = 1'b0;
        end
      endcase
    end
  end

  assign row_free = ~(idmap_q[row_q] | ((row_q == '0) ? ID_ROW_W'(1) : '0));
  assign free_bit = lowest_set(row_free);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    slot_d   = slot_q;
    row_d    = row_q;
    cnt_d    = cnt_q;
    vld_d    = vld_q;
    idmap_d  = idmap_q;
    wr_d     = wr_q;
    sts_d    = sts_q;
    rid_d    = rid_q;
    fired_d  = fired_q;
    fslot_d  = fslot_q;
    mem_we   = 1'b0;
    out_load = 1'b0;
    ovld_d   = ovld_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (in_valid_i) begin
          state_d = ST_SCAN;
          sts_d   = STS_DONE;
          rid_d   = '0;
          fired_d = 1'b0;
          fslot_d = '0;
        end
      end
      ST_SCAN: begin
        case (req_q)
          REQ_TICK: begin
            if (due) begin
              wr_d    = upd;
              slot_d  = idx_q;
              fired_d = 1'b1;
              rid_d   = ent.id;
              fslot_d = idx_q;
              state_d = ST_WRITE;
            end else if (idx_q == LAST_IDX) begin
              state_d = ST_RESP;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          REQ_ADD: begin
            if (!vld_q[idx_q]) begin
              slot_d  = idx_q;
              row_d   = '0;
              state_d = ST_IDSCAN;
            end else if (idx_q == LAST_IDX) begin
              sts_d   = STS_FULL;
              state_d = ST_RESP;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          default: begin
            if (tid_q == '0) begin
              sts_d   = STS_NOT_FOUND;
              state_d = ST_RESP;
            end else if (vld_q[idx_q] && (ent.id == tid_q)) begin
              if (req_q == REQ_REMOVE) begin
                vld_d[idx_q]                    = 1'b0;
                idmap_d[tid_q[7:4]][tid_q[3:0]] = 1'b0;
                cnt_d                           = cnt_q - 1'b1;
                state_d                         = ST_RESP;
              end else begin
                wr_d    = ent;
                wr_d.en = en_q;
                slot_d  = idx_q;
                state_d = ST_WRITE;
              end
            end else if (idx_q == LAST_IDX) begin
              sts_d   = STS_NOT_FOUND;
              state_d = ST_RESP;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
        endcase
      end
      ST_IDSCAN: begin
        if (row_free != '0) begin
          rid_d   = {row_q, free_bit};
          wr_d    = '0;
          wr_d.id = {row_q, free_bit};
          wr_d.kind = kind_q;
          wr_d.en   = en_q;
          if (kind_q == KIND_DAILY) begin
            wr_d.hour   = hour_q;
            wr_d.minute = minute_q;
          end else begin
            wr_d.interval  = ival_q;
            wr_d.prev_fire = now_q;
          end
          vld_d[slot_q]           = 1'b1;
          idmap_d[row_q][free_bit] = 1'b1;
          cnt_d                   = cnt_q + 1'b1;
          state_d                 = ST_WRITE;
        end else if (row_q == LAST_ROW) begin
          sts_d   = STS_FULL;
          state_d = ST_RESP;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      ST_WRITE: begin
        mem_we  = 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!ovld_q || out_ready_i) begin
          out_load = 1'b1;
          ovld_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      slot_q  <= '0;
      row_q   <= '0;
      cnt_q   <= '0;
      vld_q   <= '0;
      ovld_q  <= 1'b0;
      for (int r = 0; r < ID_ROWS; r++) begin
        idmap_q[r] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      slot_q  <= slot_d;
      row_q   <= row_d;
      cnt_q   <= cnt_d;
      vld_q   <= vld_d;
      ovld_q  <= ovld_d;
      idmap_q <= idmap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q     <= req_type_i;
      now_q     <= now_sec_i;
      hour_q    <= hour_i;
      minute_q  <= minute_i;
      kind_q    <= entry_kind_i;
      ival_q    <= period_sec_i;
      en_q      <= enable_flag_i;
      tid_q     <= target_id_i;
      today_q   <= 32'(cal_year_i) * DATE_YEAR_MUL + 32'(cal_month_i) * DATE_MONTH_MUL
                   + 32'(cal_day_i);
      year_ok_q <= (cal_year_i >= cfg_year_q);
    end
    wr_q    <= wr_d;
    sts_q   <= sts_d;
    rid_q   <= rid_d;
    fired_q <= fired_d;
    fslot_q <= fslot_d;
    if (out_load) begin
      o_sts_q   <= sts_q;
      o_rid_q   <= rid_q;
      o_fired_q <= fired_q;
      o_fslot_q <= 4'(fslot_q);
      o_cnt_q   <= 5'(cnt_q);
    end
  end

  assign out_valid_o   = ovld_q;
  assign status_o      = o_sts_q;
  assign result_id_o   = o_rid_q;
  assign fired_o       = o_fired_q;
  assign fired_slot_o  = o_fslot_q;
  assign entry_count_o = o_cnt_q;

endmodule

`default_nettype wire

/* rtl/core/alm_sched_checker.sv */
// ----------------------------------------------------------------------------
// alm_sched_checker
// port-level checks of the alarm schedule table, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module alm_sched_checker
  import alm_sched_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] status_o,
  input wire logic [7:0] result_id_o,
  input wire logic       fired_o,
  input wire logic [3:0] fired_slot_o
);

  // pending result holds
  `ALM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(result_id_o) && $stable(status_o))
  // a fire is always a done tick
  `ALM_ASSERT(a_fire_done, out_valid_o && fired_o |-> status_o == STS_DONE)
  // no fire reports slot zero
  `ALM_ASSERT(a_nofire_slot, out_valid_o && !fired_o |-> fired_slot_o == '0)
  // failed requests carry no id
  `ALM_ASSERT(a_err_noid, out_valid_o && status_o != STS_DONE |-> result_id_o == '0)
  // one item at a time
  `ALM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind alarm_schedule_table alm_sched_checker u_alm_sched_checker (.*);

`default_nettype wire

/* tb/alarm_schedule_table_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_schedule_table_test
// self-checking testbench of the alarm schedule table
// ----------------------------------------------------------------------------
// A short scripted sequence covers the request types, the table extremes and
// the not-found error code. It is followed by five phases of random requests, each with
// its own minimum year. Each accepted request is run through a model of the
// slot table kept here, and each reply is compared with the oldest prediction.
// Both handshakes idle at random, and the reply side once holds off long
// enough for the request side to stall.

module alarm_schedule_table_test;
  import alm_sched_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [1:0] KIND_INERT = 2'd3;
  localparam logic [2:0] ADDR_MIN_YEAR = {CFG_IDX_MIN_YEAR, 2'b00};
  localparam int PHASE_ITEMS = 340;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_sec;
    logic [13:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [1:0]  entry_kind;
    logic [31:0] period_sec;
    logic        enable_flag;
    logic [7:0]  target_id;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] result_id;
    logic       fired;
    logic [3:0] fired_slot;
    logic [4:0] entry_count;
  } reply_t;

  typedef struct {
    request_t req;
    bit       typed;
    reply_t   reply;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  request_t    drive_req = '0;
  bit          drive_typed = 1'b0;
  reply_t      drive_reply = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  reply_t      got_reply;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // model of the slot table
  logic [13:0] min_year_cfg = MIN_YEAR_RST;
  logic [7:0]  tab_id   [SLOTS] = '{default: '0};
  logic [1:0]  tab_kind [SLOTS] = '{default: '0};
  logic        tab_en   [SLOTS] = '{default: '0};
  logic        tab_done [SLOTS] = '{default: '0};
  logic [31:0] tab_int  [SLOTS] = '{default: '0};
  logic [4:0]  tab_hour [SLOTS] = '{default: '0};
  logic [5:0]  tab_min  [SLOTS] = '{default: '0};
  logic [31:0] tab_last [SLOTS] = '{default: '0};

  reply_t      expected_replies[$];
  script_row_t script_rows[$];
  int          mismatch_count = 0;
  int          hold_request = 0;
  int          sender_run = 0;
  bit          sender_calm = 1'b0;

  // stimulus state
  logic [31:0] clock_sec = 32'd1000;
  logic [4:0]  day_cur = 5'd1;
  logic [3:0]  month_cur = 4'd1;
  logic [4:0]  pool_hour [4] = '{5'd0, 5'd23, 5'd12, 5'd7};
  logic [5:0]  pool_min  [4] = '{6'd0, 6'd59, 6'd30, 6'd5};

  always #5 clk_i = ~clk_i;

  alarm_schedule_table #(
    .ENTRY_COUNT(SLOTS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (drive_req.req_type),
    .now_sec_i     (drive_req.now_sec),
    .cal_year_i    (drive_req.cal_year),
    .cal_month_i   (drive_req.cal_month),
    .cal_day_i     (drive_req.cal_day),
    .hour_i        (drive_req.hour),
    .minute_i      (drive_req.minute),
    .entry_kind_i  (drive_req.entry_kind),
    .period_sec_i  (drive_req.period_sec),
    .enable_flag_i (drive_req.enable_flag),
    .target_id_i   (drive_req.target_id),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (got_reply.status),
    .result_id_o   (got_reply.result_id),
    .fired_o       (got_reply.fired),
    .fired_slot_o  (got_reply.fired_slot),
    .entry_count_o (got_reply.entry_count),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  function automatic int find_slot(logic [7:0] id);
    for (int i = 0; i < SLOTS; i++) begin
      if (tab_id[i] == id) return i;
    end
    return -1;
  endfunction

  // applies one request to the table model and returns its reply
  function automatic reply_t table_apply(request_t r);
    reply_t      o;
    int          s;
    logic [7:0]  fresh;
    logic [31:0] today;
    logic [31:0] elapsed;
    logic [31:0] deadline;
    bit          due;
    o = '0;
    today = 32'(r.cal_year) * DATE_YEAR_MUL + 32'(r.cal_month) * DATE_MONTH_MUL
            + 32'(r.cal_day);
    case (r.req_type)
      REQ_TICK: begin
        for (int i = 0; i < SLOTS && !o.fired; i++) begin
          due = 1'b0;
          if (tab_id[i] != 8'd0 && tab_en[i]) begin
            case (tab_kind[i])
              KIND_PERIODIC: begin
                elapsed = r.now_sec - tab_last[i];
                if (tab_int[i] != 32'd0 && elapsed >= tab_int[i]) begin
                  due = 1'b1;
                  tab_last[i] = r.now_sec;
                end
              end
              KIND_DAILY: begin
                if (r.cal_year >= min_year_cfg && r.hour == tab_hour[i] &&
                    r.minute == tab_min[i] && tab_last[i] != today) begin
                  due = 1'b1;
                  tab_last[i] = today;
                end
              end
              KIND_ONESHOT: begin
                deadline = tab_last[i] + tab_int[i];
                if (!tab_done[i] && tab_int[i] != 32'd0 && r.now_sec >= deadline) begin
                  due = 1'b1;
                  tab_done[i] = 1'b1;
                  tab_en[i] = 1'b0;
                end
              end
              default: ;
            endcase
          end
          if (due) begin
            o.fired = 1'b1;
            o.result_id = tab_id[i];
            o.fired_slot = 4'(i);
          end
        end
      end
      REQ_ADD: begin
        s = find_slot(8'd0);
        fresh = 8'd0;
        if (s >= 0) begin
          for (int cand = 255; cand >= 1; cand--) begin
            if (find_slot(8'(cand)) < 0) fresh = 8'(cand);
          end
        end
        if (s < 0 || fresh == 8'd0) begin
          o.status = STS_FULL;
        end else begin
          tab_id[s] = fresh;
          tab_kind[s] = r.entry_kind;
          tab_en[s] = r.enable_flag;
          tab_done[s] = 1'b0;
          if (r.entry_kind == KIND_DAILY) begin
            tab_hour[s] = r.hour;
            tab_min[s] = r.minute;
            tab_int[s] = 32'd0;
            tab_last[s] = 32'd0;
          end else begin
            tab_hour[s] = 5'd0;
            tab_min[s] = 6'd0;
            tab_int[s] = r.period_sec;
            tab_last[s] = r.now_sec;
          end
          o.result_id = fresh;
        end
      end
      default: begin
        s = (r.target_id != 8'd0) ? find_slot(r.target_id) : -1;
        if (s < 0) begin
          o.status = STS_NOT_FOUND;
        end else if (r.req_type == REQ_REMOVE) begin
          tab_id[s] = 8'd0;
          tab_kind[s] = 2'd0;
          tab_en[s] = 1'b0;
          tab_done[s] = 1'b0;
          tab_int[s] = 32'd0;
          tab_hour[s] = 5'd0;
          tab_min[s] = 6'd0;
          tab_last[s] = 32'd0;
        end else begin
          tab_en[s] = r.enable_flag;
        end
      end
    endcase
    for (int i = 0; i < SLOTS; i++) begin
      if (tab_id[i] != 8'd0) o.entry_count = o.entry_count + 5'd1;
    end
    return o;
  endfunction

  function automatic request_t tick_req(logic [31:0] now, logic [13:0] year,
                                        logic [3:0] month, logic [4:0] day,
                                        logic [4:0] hr, logic [5:0] mn);
    request_t r;
    r = '0;
    r.req_type = REQ_TICK;
    r.now_sec = now;
    r.cal_year = year;
    r.cal_month = month;
    r.cal_day = day;
    r.hour = hr;
    r.minute = mn;
    return r;
  endfunction

  function automatic request_t add_req(logic [31:0] now, logic [1:0] kind,
                                       logic [31:0] ival, logic [4:0] hr,
                                       logic [5:0] mn, logic en);
    request_t r;
    r = '0;
    r.req_type = REQ_ADD;
    r.now_sec = now;
    r.entry_kind = kind;
    r.period_sec = ival;
    r.hour = hr;
    r.minute = mn;
    r.enable_flag = en;
    return r;
  endfunction

  function automatic request_t id_req(logic [1:0] kind, logic [7:0] id, logic en);
    request_t r;
    r = '0;
    r.req_type = kind;
    r.target_id = id;
    r.enable_flag = en;
    return r;
  endfunction

  function automatic reply_t reply(logic [1:0] st, logic [7:0] id, logic f,
                                   logic [3:0] slot, logic [4:0] cnt);
    reply_t o;
    o.status = st;
    o.result_id = id;
    o.fired = f;
    o.fired_slot = slot;
    o.entry_count = cnt;
    return o;
  endfunction

  task automatic add_row(request_t r, bit typed, reply_t o);
    script_row_t row;
    row.req = r;
    row.typed = typed;
    row.reply = o;
    script_rows.push_back(row);
  endtask

  // random request, mostly near the current clock and the entries in the table
  function automatic request_t random_item();
    request_t     r;
    logic [127:0] noise;
    int           k;
    int           p;
    int           y;
    noise = {$urandom, $urandom, $urandom, $urandom};
    r = noise[$bits(request_t)-1:0];
    k = $urandom_range(0, 99);
    if (k < 45) r.req_type = REQ_TICK;
    else if (k < 70) r.req_type = REQ_ADD;
    else if (k < 82) r.req_type = REQ_REMOVE;
    else r.req_type = REQ_SETEN;
    k = $urandom_range(0, 99);
    if (k < 80) clock_sec = clock_sec + $urandom_range(0, 15);
    else if (k < 90) clock_sec = clock_sec + $urandom_range(0, 100000);
    else clock_sec = $urandom;
    if ($urandom_range(0, 19) == 0) begin
      day_cur = (day_cur == 5'd31) ? 5'd1 : day_cur + 5'd1;
      month_cur = (month_cur == 4'd12) ? 4'd1 : month_cur + 4'd1;
    end
    if ($urandom_range(0, 4) != 0) begin
      p = $urandom_range(0, 3);
      r.hour = pool_hour[p];
      r.minute = pool_min[p];
    end
    case (r.req_type)
      REQ_TICK: begin
        r.now_sec = clock_sec;
        k = $urandom_range(0, 99);
        if (k < 50) begin
          y = int'(min_year_cfg) + $urandom_range(0, 2) - 1;
          if (y < 0) y = 0;
          if (y > 16383) y = 16383;
          r.cal_year = 14'(y);
        end else if (k < 80) begin
          r.cal_year = 14'($urandom_range(2020, 2030));
        end
        if ($urandom_range(0, 4) != 0) begin
          r.cal_day = day_cur;
          r.cal_month = month_cur;
        end
      end
      REQ_ADD: begin
        r.now_sec = clock_sec;
        k = $urandom_range(0, 99);
        if (k < 30) r.entry_kind = KIND_PERIODIC;
        else if (k < 60) r.entry_kind = KIND_DAILY;
        else if (k < 90) r.entry_kind = KIND_ONESHOT;
        else r.entry_kind = KIND_INERT;
        k = $urandom_range(0, 99);
        if (k < 60) r.period_sec = $urandom_range(1, 20);
        else if (k < 75) r.period_sec = 32'd0;
        else if (k < 90) r.period_sec = $urandom_range(21, 5000);
        r.enable_flag = ($urandom_range(0, 99) < 85);
      end
      default: begin
        p = $urandom_range(0, SLOTS - 1);
        if (tab_id[p] != 8'd0 && $urandom_range(0, 4) != 0) r.target_id = tab_id[p];
        else if ($urandom_range(0, 19) == 0) r.target_id = 8'd0;
      end
    endcase
    return r;
  endfunction

  task automatic send_item(request_t r, bit typed, reply_t o);
    int gap;
    int k;
    if (sender_run == 0) begin
      sender_calm = ($urandom_range(0, 2) == 0);
      sender_run = $urandom_range(20, 100);
    end
    sender_run--;
    gap = 0;
    if (!sender_calm) begin
      k = $urandom_range(0, 9);
      if (k == 9) gap = $urandom_range(10, 40);
      else if (k >= 5) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    drive_req <= r;
    drive_typed <= typed;
    drive_reply <= o;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_min_year(logic [13:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MIN_YEAR;
    pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    min_year_cfg = value;
    // read it back
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[13:0] !== value) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("min year readback: expected %0d got %0d", value, prdata[13:0]);
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // prediction on request accept, comparison on reply accept
  always @(posedge clk_i) begin
    reply_t exp;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        exp = table_apply(drive_req);
        if (drive_typed) exp = drive_reply;
        expected_replies.push_back(exp);
      end
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected reply: status %0d id %0d fired %0d slot %0d count %0d",
                     got_reply.status, got_reply.result_id, got_reply.fired,
                     got_reply.fired_slot, got_reply.entry_count);
        end else begin
          exp = expected_replies.pop_front();
          if (got_reply.status !== exp.status || got_reply.result_id !== exp.result_id ||
              got_reply.fired !== exp.fired || got_reply.fired_slot !== exp.fired_slot ||
              got_reply.entry_count !== exp.entry_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("reply mismatch: expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                       exp.status, exp.result_id, exp.fired, exp.fired_slot,
                       exp.entry_count, got_reply.status, got_reply.result_id,
                       got_reply.fired, got_reply.fired_slot, got_reply.entry_count);
          end
        end
      end
    end
  end

  // reply side: calm and busy stretches, plus one long hold-off on request
  initial begin
    int  burst;
    int  hold;
    bit  calm;
    burst = 0;
    hold = 0;
    calm = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (burst == 0) begin
        calm = ($urandom_range(0, 2) == 0);
        burst = $urandom_range(50, 300);
      end
      burst--;
      if (hold == 0 && !calm && $urandom_range(0, 3) == 0)
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [13:0] phase_year [5];
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table, error codes
    add_row(tick_req(32'd0, 14'd2024, 4'd1, 5'd1, 5'd0, 6'd0), 1'b1,
            reply(STS_DONE, 8'd0, 1'b0, 4'd0, 5'd0));
    add_row(id_req(REQ_REMOVE, 8'd0, 1'b0), 1'b1,
            reply(STS_NOT_FOUND, 8'd0, 1'b0, 4'd0, 5'd0));
    add_row(id_req(REQ_SETEN, 8'd255, 1'b1), 1'b1,
            reply(STS_NOT_FOUND, 8'd0, 1'b0, 4'd0, 5'd0));
    // one entry of each kind, zero interval
    add_row(add_req(32'd100, KIND_PERIODIC, 32'd10, 5'd0, 6'd0, 1'b1), 1'b1,
            reply(STS_DONE, 8'd1, 1'b0, 4'd0, 5'd1));
    add_row(add_req(32'd100, KIND_DAILY, 32'd7, 5'd23, 6'd59, 1'b1), 1'b1,
            reply(STS_DONE, 8'd2, 1'b0, 4'd0, 5'd2));
    add_row(add_req(32'd100, KIND_ONESHOT, 32'd5, 5'd0, 6'd0, 1'b1), 1'b1,
            reply(STS_DONE, 8'd3, 1'b0, 4'd0, 5'd3));
    add_row(add_req(32'd0, KIND_INERT, 32'd1, 5'd0, 6'd0, 1'b1), 1'b1,
            reply(STS_DONE, 8'd4, 1'b0, 4'd0, 5'd4));
    add_row(add_req(32'd0, KIND_PERIODIC, 32'd0, 5'd0, 6'd0, 1'b1), 1'b1,
            reply(STS_DONE, 8'd5, 1'b0, 4'd0, 5'd5));
    // one-shot due, periodic due, daily due, then nothing
    add_row(tick_req(32'd105, 14'd2024, 4'd12, 5'd31, 5'd0, 6'd0), 1'b0, '0);
    add_row(tick_req(32'd110, 14'd2024, 4'd12, 5'd31, 5'd23, 6'd59), 1'b0, '0);
    add_row(tick_req(32'd110, 14'd2024, 4'd12, 5'd31, 5'd23, 6'd59), 1'b0, '0);
    add_row(tick_req(32'd110, 14'd2024, 4'd12, 5'd31, 5'd23, 6'd59), 1'b0, '0);
    // re-enabled one-shot stays quiet, daily gated by year
    add_row(id_req(REQ_SETEN, 8'd3, 1'b1), 1'b1,
            reply(STS_DONE, 8'd0, 1'b0, 4'd0, 5'd5));
    add_row(tick_req(32'd111, 14'd2023, 4'd1, 5'd1, 5'd23, 6'd59), 1'b0, '0);
    add_row(tick_req(32'd111, 14'd2024, 4'd1, 5'd1, 5'd23, 6'd59), 1'b0, '0);
    add_row(tick_req(32'hFFFF_FFFF, 14'h3FFF, 4'hF, 5'h1F, 5'h1F, 6'h3F), 1'b0, '0);
    add_row(id_req(REQ_SETEN, 8'd1, 1'b0), 1'b1,
            reply(STS_DONE, 8'd0, 1'b0, 4'd0, 5'd5));
    add_row(tick_req(32'd0, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0), 1'b0, '0);
    // periodic across the wrap of the seconds counter
    add_row(add_req(32'hFFFF_FFF0, KIND_PERIODIC, 32'h20, 5'd0, 6'd0, 1'b1), 1'b1,
            reply(STS_DONE, 8'd6, 1'b0, 4'd0, 5'd6));
    add_row(tick_req(32'h10, 14'd2024, 4'd2, 5'd2, 5'd0, 6'd0), 1'b0, '0);
    // freed id and slot are reused first
    add_row(id_req(REQ_REMOVE, 8'd2, 1'b0), 1'b1,
            reply(STS_DONE, 8'd0, 1'b0, 4'd0, 5'd5));
    add_row(add_req(32'd0, KIND_DAILY, 32'd0, 5'd0, 6'd0, 1'b0), 1'b1,
            reply(STS_DONE, 8'd2, 1'b0, 4'd0, 5'd6));
    add_row(id_req(REQ_REMOVE, 8'd200, 1'b1), 1'b1,
            reply(STS_NOT_FOUND, 8'd0, 1'b0, 4'd0, 5'd6));
    // one-shot deadline that wraps
    add_row(add_req(32'hFFFF_FFFF, KIND_ONESHOT, 32'hFFFF_FFFF, 5'd0, 6'd0, 1'b1), 1'b1,
            reply(STS_DONE, 8'd7, 1'b0, 4'd0, 5'd7));
    add_row(tick_req(32'hFFFF_FFFE, 14'd2024, 4'd3, 5'd3, 5'd1, 6'd0), 1'b0, '0);

    foreach (script_rows[i])
      send_item(script_rows[i].req, script_rows[i].typed, script_rows[i].reply);
    wait_idle();

    phase_year[0] = 14'd0;
    phase_year[1] = 14'h3FFF;
    phase_year[2] = 14'd9999;
    phase_year[3] = MIN_YEAR_RST;
    phase_year[4] = 14'($urandom_range(0, 9999));
    for (int phase = 0; phase < 5; phase++) begin
      write_min_year(phase_year[phase]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == 100) hold_request = HOLD_CYCLES;
        send_item(random_item(), 1'b0, '0);
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
